### hw/rtl/masked_flow_aggregation_table_core_macros.svh
// Assertion macros for the flow aggregation table core.
// Included by files that carry concurrent checks.
`ifndef MASKED_FLOW_AGGREGATION_TABLE_CORE_MACROS_SVH
`define MASKED_FLOW_AGGREGATION_TABLE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MFAT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
`define MFAT_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define MFAT_ASSERT(label, clk, rst_n, prop)
`define MFAT_ASSERT_NORST(label, clk, prop)
`endif
`endif

### hw/rtl/mfat_pkg.sv
// Shared types and constants for the flow aggregation table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mfat_pkg;
  localparam int unsigned TableDepthDefault = 1024;
  localparam int unsigned ByteWidthDefault  = 48;
  localparam int unsigned AddrBits          = 32;
  localparam int unsigned CfgAddrW          = 3;
  localparam int unsigned CfgDataW          = 6;
  localparam int unsigned FlowsW            = 11;

  localparam logic [CfgAddrW-1:0] RegKeepSrcAddr = 3'd0;
  localparam logic [CfgAddrW-1:0] RegKeepDstAddr = 3'd1;
  localparam logic [CfgAddrW-1:0] RegKeepSrcPort = 3'd2;
  localparam logic [CfgAddrW-1:0] RegKeepDstPort = 3'd3;
  localparam logic [CfgAddrW-1:0] RegPrefixLen   = 3'd4;

  typedef enum logic [1:0] {
    StNew = 2'd0, StAgg = 2'd1, StFull = 2'd2, StEmptyMask = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BkIdle, BkScan, BkRead, BkDone
  } bk_state_e;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  protocol;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] flow_bytes;
    logic [7:0]  flow_protocol;
    logic [10:0] flows_seen;
  } out_item_t;

  typedef struct packed {
    logic        empty_mask;
    logic [31:0] skey;
    logic [31:0] dkey;
    logic [31:0] pkey;
    logic [7:0]  protocol;
    logic [15:0] packet_length;
  } key_item_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [5:0] l;
    l = (len > 6'd32) ? 6'd32 : len;
    if (l == 6'd0) return 32'd0;
    return 32'hffff_ffff << (6'd32 - l);
  endfunction
endpackage
`default_nettype wire

### hw/rtl/masked_flow_aggregation_table_core.sv
// An empty mask skips the scan; otherwise the stored flows are compared in turn, ending at
// the first hit, after the last stored flow on a miss, or after the last entry when full.
// Throughput: one item at a time; the next item starts once the result is popped.
// Reset clears the flow count and the control registers at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "masked_flow_aggregation_table_core_macros.svh"
module masked_flow_aggregation_table_core import mfat_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault,
  parameter int unsigned ByteWidth  = ByteWidthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                push,
  input  wire in_item_t            in_item_i,
  output logic                     full,
  output logic                     empty,
  output out_item_t                out_item_o,
  input  wire logic                pop
);
  logic kv, kpop;
  key_item_t key;

  mfat_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push_i(push), .item_i(in_item_i), .full_o(full),
    .kv_o(kv), .key_o(key), .kpop_i(kpop)
  );

  mfat_back #(.TableDepth(TableDepth), .ByteWidth(ByteWidth)) u_back (
    .clk_i, .rst_ni, .kv_i(kv), .key_i(key), .kpop_o(kpop),
    .empty_o(empty), .res_o(out_item_o), .pop_i(pop)
  );

  `MFAT_ASSERT(a_pop_needs_key, clk_i, rst_ni, kpop |-> kv)
  `MFAT_ASSERT(a_result_after_pop, clk_i, rst_ni, kpop |=> !empty)
  `MFAT_ASSERT(a_flows_bounded, clk_i, rst_ni, !empty |-> out_item_o.flows_seen <= 11'(TableDepth))
endmodule
`default_nettype wire

### hw/rtl/mfat_front.sv
// Front end: registers and masks incoming headers into flow keys.
// Depends on mfat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfat_front import mfat_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                push_i,
  input  wire in_item_t            item_i,
  output logic                     full_o,
  output logic                     kv_o,
  output key_item_t                key_o,
  input  wire logic                kpop_i
);
  logic ksa_q, kda_q, ksp_q, kdp_q;
  logic [5:0] plen_q;
  logic v_q;
  key_item_t k_q, k_d;
  logic [31:0] pm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksa_q <= 1'b1; kda_q <= 1'b1; ksp_q <= 1'b0; kdp_q <= 1'b1;
      plen_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKeepSrcAddr: ksa_q <= cfg_data_i[0];
        RegKeepDstAddr: kda_q <= cfg_data_i[0];
        RegKeepSrcPort: ksp_q <= cfg_data_i[0];
        RegKeepDstPort: kdp_q <= cfg_data_i[0];
        RegPrefixLen:   plen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pm = prefix_mask(plen_q);
    k_d.empty_mask = !(ksa_q | kda_q | ksp_q | kdp_q);
    k_d.skey = ksa_q ? (item_i.source_address & pm) : 32'd0;
    k_d.dkey = kda_q ? (item_i.dest_address & pm) : 32'd0;
    k_d.pkey = {ksp_q ? item_i.source_port : 16'd0, kdp_q ? item_i.dest_port : 16'd0};
    k_d.protocol = item_i.protocol;
    k_d.packet_length = item_i.packet_length;
  end

  assign full_o = v_q;
  assign kv_o = v_q;
  assign key_o = k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (push_i && !v_q) v_q <= 1'b1;
    else if (kpop_i) v_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !v_q) k_q <= k_d;
  end
endmodule
`default_nettype wire

### hw/rtl/mfat_back.sv
// Back end: scans the stored flows in the table memory and updates it.
// Depends on mfat_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfat_back import mfat_pkg::*; #(
  parameter int unsigned TableDepth = TableDepthDefault,
  parameter int unsigned ByteWidth  = ByteWidthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      kv_i,
  input  wire key_item_t key_i,
  output logic           kpop_o,
  output logic           empty_o,
  output out_item_t      res_o,
  input  wire logic      pop_i
);
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [ByteWidth-1:0] ByteMax = '1;

  typedef struct packed {
    logic [31:0] s;
    logic [31:0] d;
    logic [31:0] p;
    logic [7:0]  pr;
    logic [ByteWidth-1:0] b;
  } ent_t;

  ent_t mem [TableDepth];
  ent_t rd_q;
  logic [IdxW:0] idx_q, idx_d;
  logic [IdxW-1:0] hit_q, hit_d, free_q, free_d;
  logic found_q, found_d, hasfree_q, hasfree_d;
  logic [CntW-1:0] cnt_q;
  bk_state_e st_q, st_d;
  logic ov_q;
  out_item_t res_q;
  logic [ByteWidth:0] sum;
  logic mem_we;
  logic [IdxW-1:0] mem_wa;
  ent_t mem_wd;
  logic match;

  always_ff @(posedge clk_i) begin
    rd_q <= mem[idx_q[IdxW-1:0]];
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  assign match = rd_q.s == key_i.skey && rd_q.d == key_i.dkey && rd_q.p == key_i.pkey;
  assign sum = {1'b0, rd_q.b} + {{(ByteWidth-15){1'b0}}, key_i.packet_length};

  always_comb begin
    st_d = st_q; idx_d = idx_q; hit_d = hit_q; free_d = free_q;
    found_d = found_q; hasfree_d = hasfree_q;
    case (st_q)
      BkIdle: begin
        idx_d = '0; found_d = 1'b0; hasfree_d = 1'b0;
        if (kv_i && !ov_q) st_d = key_i.empty_mask ? BkDone : BkScan;
      end
      BkScan: begin
        if (idx_q < (IdxW+1)'(cnt_q)) begin
          st_d = BkRead;
        end else begin
          hasfree_d = 1'b1; free_d = idx_q[IdxW-1:0]; st_d = BkDone;
        end
      end
      BkRead: st_d = BkDone;
      BkDone: st_d = BkIdle;
      default: st_d = BkIdle;
    endcase
    if (st_q == BkRead) begin
      if (match) begin
        found_d = 1'b1; hit_d = idx_q[IdxW-1:0]; st_d = BkDone;
      end else begin
        idx_d = idx_q + 1'b1;
        st_d = (idx_q == (IdxW+1)'(TableDepth - 1)) ? BkDone : BkScan;
      end
    end
  end

  always_comb begin
    mem_we = 1'b0; mem_wa = free_q; mem_wd = rd_q;
    kpop_o = (st_q == BkDone);
    if (st_q == BkDone && !key_i.empty_mask) begin
      if (found_q) begin
        mem_we = 1'b1; mem_wa = hit_q;
        mem_wd.b = sum[ByteWidth] ? ByteMax : sum[ByteWidth-1:0];
      end else if (hasfree_q) begin
        mem_we = 1'b1; mem_wa = free_q;
        mem_wd.s = key_i.skey; mem_wd.d = key_i.dkey; mem_wd.p = key_i.pkey;
        mem_wd.pr = key_i.protocol;
        mem_wd.b = ByteWidth'(key_i.packet_length);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle; idx_q <= '0; found_q <= 1'b0; hasfree_q <= 1'b0;
      cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; found_q <= found_d; hasfree_q <= hasfree_d;
      if (pop_i && ov_q) ov_q <= 1'b0;
      if (st_q == BkDone) begin
        ov_q <= 1'b1;
        if (!key_i.empty_mask && !found_q && hasfree_q) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit_d; free_q <= free_d;
    if (st_q == BkDone) begin
      res_q.flows_seen <= FlowsW'(cnt_q);
      res_q.status <= StFull; res_q.flow_bytes <= '0; res_q.flow_protocol <= '0;
      if (key_i.empty_mask) begin
        res_q.status <= StEmptyMask;
      end else if (found_q) begin
        res_q.status <= StAgg;
        res_q.flow_bytes <= 48'(sum[ByteWidth] ? ByteMax : sum[ByteWidth-1:0]);
        res_q.flow_protocol <= rd_q.pr;
      end else if (hasfree_q) begin
        res_q.status <= StNew;
        res_q.flow_bytes <= 48'(key_i.packet_length);
        res_q.flow_protocol <= key_i.protocol;
        res_q.flows_seen <= FlowsW'(cnt_q + 1'b1);
      end
    end
  end

  assign empty_o = !ov_q;
  assign res_o = res_q;
endmodule
`default_nettype wire
